/* hdl/sadb_pkg.sv */
// ----------------------------------------------------------------------------
// sadb_pkg
// Shared constants, types and width helpers of the stick axis calibration and
// deadband pipeline.
// ----------------------------------------------------------------------------
package sadb_pkg;

	// Calibration register width and default geometry
	localparam int CAL_W           = 16;
	localparam int SAMPLE_BITS_DEF = 12;
	localparam int NORM_STEPS_DEF  = 512;
	localparam int BYTE_W          = 8;
	localparam int CFG_IDX_W       = 3;

	// Configuration register indexes
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_CAL_MIN       = cfg_idx_t'(0);
	localparam cfg_idx_t REG_CAL_CENTER    = cfg_idx_t'(1);
	localparam cfg_idx_t REG_CAL_MAX       = cfg_idx_t'(2);
	localparam cfg_idx_t REG_INVERT_AXIS   = cfg_idx_t'(3);
	localparam cfg_idx_t REG_THROTTLE_MODE = cfg_idx_t'(4);

	// Control flags that travel with each item down the pipeline
	typedef struct packed {
		logic vld;  // stage holds an item
		logic res;  // sample was nonzero
		logic thr;  // throttle mapping
		logic neg;  // quotient is negative
	} ctl_t;

	// Quotient width: holds 0..norm_steps
	function automatic int quot_w(int norm_steps);
		return $clog2(norm_steps + 1);
	endfunction

	// Dividend width: 2 * |num| * norm_steps + |den|
	function automatic int num_w(int norm_steps);
		return CAL_W + $clog2(norm_steps) + 2;
	endfunction

endpackage

/* hdl/sadb_sample_if.sv */
// ----------------------------------------------------------------------------
// sadb_sample_if
// Input channel: one raw converter sample per item.
// ----------------------------------------------------------------------------
interface sadb_sample_if #(
	parameter int SW = 12
);
	logic          valid;
	logic          ready;
	logic [SW-1:0] adc_sample;

	modport source (output valid, output adc_sample, input ready);
	modport sink (input valid, input adc_sample, output ready);
endinterface

/* hdl/sadb_result_if.sv */
// ----------------------------------------------------------------------------
// sadb_result_if
// Output channel: normalized position and command byte per item.
// ----------------------------------------------------------------------------
interface sadb_result_if #(
	parameter int NW = 11
);
	logic                 valid;
	logic                 ready;
	logic                 valid_res;
	logic signed [NW-1:0] norm_steps;
	logic signed [7:0]    stick_byte;

	modport source (output valid, output valid_res, output norm_steps, output stick_byte,
		input ready);
	modport sink (input valid, input valid_res, input norm_steps, input stick_byte,
		output ready);
endinterface

/* hdl/sadb_front.sv */
// ----------------------------------------------------------------------------
// sadb_front
// Sample conditioning and divider setup: inversion, span selection, magnitude
// and sign split, dividend/divisor forming and the saturation check.
// ----------------------------------------------------------------------------
module sadb_front #(
	parameter int SW = 12,
	parameter int N  = 512
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           in_vld,
	input  logic [SW-1:0]                  sample,
	input  logic [sadb_pkg::CAL_W-1:0]     cal_min,
	input  logic [sadb_pkg::CAL_W-1:0]     cal_center,
	input  logic [sadb_pkg::CAL_W-1:0]     cal_max,
	input  logic                           invert,
	input  logic                           thr,
	output sadb_pkg::ctl_t                 ctl_o,
	output logic                           frc_o,
	output logic [sadb_pkg::quot_w(N)-1:0] fval_o,
	output logic [sadb_pkg::num_w(N)-1:0]  x_o,
	output logic [sadb_pkg::num_w(N)-1:0]  d_o
);
	import sadb_pkg::*;

	localparam int QW = quot_w(N);
	localparam int XW = num_w(N);
	localparam int SGW = CAL_W + 2;

	// Stage 1: invert, select span, split sign and magnitude
	logic [SW-1:0]         val;
	logic signed [SGW-1:0] vx, cmin, ccen, cmax, num, den, num_abs, den_abs;
	logic                  below;

	always_comb begin
		val     = invert ? SW'(~sample + SW'(1)) : sample;
		vx      = $signed(SGW'(val));
		cmin    = $signed(SGW'(cal_min));
		ccen    = $signed(SGW'(cal_center));
		cmax    = $signed(SGW'(cal_max));
		below   = vx < ccen;
		if (thr) begin
			num = vx - cmin;
			den = cmax - cmin;
		end else begin
			num = vx - ccen;
			den = below ? ccen - cmin : cmax - ccen;
		end
		num_abs = num[SGW-1] ? -num : num;
		den_abs = den[SGW-1] ? -den : den;
	end

	ctl_t             ctl_s1;
	logic [CAL_W-1:0] a_s1, d_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1.vld <= in_vld;
			ctl_s1.res <= sample != '0;
			ctl_s1.thr <= thr;
			ctl_s1.neg <= num[SGW-1] ^ den[SGW-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1 <= CAL_W'(num_abs);
			d_s1 <= CAL_W'(den_abs);
		end
	end

	// Stage 2: form rounding dividend, doubled divisor, saturation check
	logic [XW-1:0] prod, x, dd, lim;
	logic          dz;

	always_comb begin
		prod = XW'(a_s1) * XW'(N);
		x    = {prod[XW-2:0], 1'b0} + XW'(d_s1);
		dd   = {XW'(d_s1)} << 1;
		lim  = dd * XW'(N + 1);
		dz   = d_s1 == '0;
	end

	ctl_t          ctl_s2;
	logic          frc_s2;
	logic [QW-1:0] fval_s2;
	logic [XW-1:0] x_s2, d_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			frc_s2  <= dz || (x >= lim);
			fval_s2 <= (dz && a_s1 == '0) ? '0 : QW'(N);
			x_s2    <= x;
			d_s2    <= dd;
		end
	end

	assign ctl_o  = ctl_s2;
	assign frc_o  = frc_s2;
	assign fval_o = fval_s2;
	assign x_o    = x_s2;
	assign d_o    = d_s2;

endmodule

/* hdl/sadb_div.sv */
// ----------------------------------------------------------------------------
// sadb_div
// Pipelined restoring divider: one quotient bit per stage, saturated result
// bypassed alongside.
// ----------------------------------------------------------------------------
module sadb_div #(
	parameter int N = 512
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  sadb_pkg::ctl_t                 ctl_i,
	input  logic                           frc_i,
	input  logic [sadb_pkg::quot_w(N)-1:0] fval_i,
	input  logic [sadb_pkg::num_w(N)-1:0]  x_i,
	input  logic [sadb_pkg::num_w(N)-1:0]  d_i,
	output sadb_pkg::ctl_t                 ctl_o,
	output logic [sadb_pkg::quot_w(N)-1:0] mag_o
);
	import sadb_pkg::*;

	localparam int QW = quot_w(N);
	localparam int XW = num_w(N);

	ctl_t          ctl_s  [QW];
	logic [XW-1:0] rem_s  [QW];
	logic [XW-1:0] d_s    [QW];
	logic [QW-1:0] q_s    [QW];
	logic          frc_s  [QW];
	logic [QW-1:0] fval_s [QW];

	for (genvar k = 0; k < QW; k++) begin : g_bit
		localparam int B = QW - 1 - k;

		ctl_t          ctl_in;
		logic [XW-1:0] rem_in, d_in, trial;
		logic [QW-1:0] q_in, fval_in;
		logic          frc_in, ge;

		if (k == 0) begin : g_head
			assign ctl_in  = ctl_i;
			assign rem_in  = x_i;
			assign d_in    = d_i;
			assign q_in    = '0;
			assign frc_in  = frc_i;
			assign fval_in = fval_i;
		end else begin : g_tail
			assign ctl_in  = ctl_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign d_in    = d_s[k-1];
			assign q_in    = q_s[k-1];
			assign frc_in  = frc_s[k-1];
			assign fval_in = fval_s[k-1];
		end

		// Try subtracting the shifted divisor for this quotient bit
		assign trial = d_in << B;
		assign ge    = rem_in >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[k] <= '0;
			end else if (en) begin
				ctl_s[k] <= ctl_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? rem_in - trial : rem_in;
				q_s[k]    <= q_in | (QW'(ge) << B);
				d_s[k]    <= d_in;
				frc_s[k]  <= frc_in;
				fval_s[k] <= fval_in;
			end
		end
	end

	// Take saturated value where the check fired
	assign ctl_o = ctl_s[QW-1];
	assign mag_o = frc_s[QW-1] ? fval_s[QW-1] : q_s[QW-1];

endmodule

/* hdl/sadb_scale.sv */
// ----------------------------------------------------------------------------
// sadb_scale
// Sign and clamp of the normalized value, deadband and byte scaling through a
// reciprocal multiply with one correction step.
// ----------------------------------------------------------------------------
module sadb_scale #(
	parameter int N = 512
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   en,
	input  sadb_pkg::ctl_t                         ctl_i,
	input  logic [sadb_pkg::quot_w(N)-1:0]         mag_i,
	output sadb_pkg::ctl_t                         ctl_o,
	output logic signed [sadb_pkg::quot_w(N):0]    norm_o,
	output logic signed [sadb_pkg::BYTE_W-1:0]     byte_o
);
	import sadb_pkg::*;

	localparam int     QW   = quot_w(N);
	localparam int     NW   = QW + 1;
	localparam longint C_AX = longint'(39) * N;
	localparam longint C_TH = longint'(N);
	localparam longint VMAX = C_AX * 127;
	localparam int     K    = $clog2(VMAX + 1);
	localparam int     VW   = K;
	localparam longint M_AX = (longint'(1) << K) / C_AX;
	localparam longint M_TH = (longint'(1) << K) / C_TH;
	localparam int     MW   = $clog2(M_TH + 1);
	localparam int     PW   = VW + MW;
	localparam int     TW   = QW + 6;

	// Stage 1: signed position, deadband offset (axis mode), numerator times 127
	logic signed [NW-1:0] norm;
	logic [TW-1:0]        t40;
	logic [VW-1:0]        base, v;
	logic                 inside_db;

	always_comb begin
		t40       = TW'(mag_i) * TW'(40);
		inside_db = t40 <= TW'(N);
		if (!ctl_i.res) begin
			norm = '0;
			base = '0;
		end else if (ctl_i.thr) begin
			norm = ctl_i.neg ? '0 : $signed(NW'(mag_i));
			base = ctl_i.neg ? '0 : VW'(mag_i);
		end else begin
			norm = ctl_i.neg ? -$signed(NW'(mag_i)) : $signed(NW'(mag_i));
			base = inside_db ? '0 : VW'(t40 - TW'(N));
		end
		v = base * VW'(127);
	end

	ctl_t                 ctl_s1;
	logic signed [NW-1:0] norm_s1;
	logic [VW-1:0]        v_s1;
	logic                 sneg_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			norm_s1 <= norm;
			v_s1    <= v;
			sneg_s1 <= !ctl_i.thr && ctl_i.neg;
		end
	end

	// Stage 2: multiply by the reciprocal of the divisor
	ctl_t                 ctl_s2;
	logic signed [NW-1:0] norm_s2;
	logic [VW-1:0]        v_s2;
	logic [PW-1:0]        prod_s2;
	logic                 sneg_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			norm_s2 <= norm_s1;
			v_s2    <= v_s1;
			prod_s2 <= PW'(v_s1) * (ctl_s1.thr ? PW'(M_TH) : PW'(M_AX));
			sneg_s2 <= sneg_s1;
		end
	end

	// Stage 3: correct the estimate by one, apply sign
	logic [BYTE_W-1:0] q0, q;
	logic [VW-1:0]     c, r;

	always_comb begin
		q0 = BYTE_W'(prod_s2 >> K);
		c  = ctl_s2.thr ? VW'(C_TH) : VW'(C_AX);
		r  = v_s2 - VW'(q0) * c;
		q  = (r >= c) ? q0 + BYTE_W'(1) : q0;
	end

	ctl_t                     ctl_s3;
	logic signed [NW-1:0]     norm_s3;
	logic signed [BYTE_W-1:0] byte_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
		end else if (en) begin
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			norm_s3 <= norm_s2;
			byte_s3 <= sneg_s2 ? -$signed(q) : $signed(q);
		end
	end

	assign ctl_o  = ctl_s3;
	assign norm_o = norm_s3;
	assign byte_o = byte_s3;

endmodule

/* hdl/sadb_skid.sv */
// ----------------------------------------------------------------------------
// sadb_skid
// Two-entry output buffer; its registered fill level stalls the pipeline so
// no path runs from the output ready back to the input.
// ----------------------------------------------------------------------------
module sadb_skid #(
	parameter int NW = 11
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	input  logic                              res_i,
	input  logic signed [NW-1:0]              norm_i,
	input  logic signed [sadb_pkg::BYTE_W-1:0] byte_i,
	output logic                              en,
	sadb_result_if.source                     result
);
	import sadb_pkg::*;

	logic                     res_q  [2];
	logic signed [NW-1:0]     norm_q [2];
	logic signed [BYTE_W-1:0] byte_q [2];
	logic                     wr_q, rd_q;
	logic [1:0]               cnt_q;
	logic                     pop;

	assign pop = result.valid && result.ready;
	assign en  = cnt_q != 2'd2;

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	// Hold items
	always_ff @(posedge clk) begin
		if (push) begin
			res_q[wr_q]  <= res_i;
			norm_q[wr_q] <= norm_i;
			byte_q[wr_q] <= byte_i;
		end
	end

	assign result.valid      = cnt_q != '0;
	assign result.valid_res  = res_q[rd_q];
	assign result.norm_steps = norm_q[rd_q];
	assign result.stick_byte = byte_q[rd_q];

endmodule

/* hdl/stick_axis_calibrate_deadband_core.sv */
// ----------------------------------------------------------------------------
// stick_axis_calibrate_deadband_core
// Three-point stick calibration with deadband and byte scaling.
// ----------------------------------------------------------------------------
// Takes one item per clock while the output buffer is not full and gives one
// result per item, in order. From input to output an item passes two setup
// stages, one restoring-divider stage per quotient bit, three scaling stages
// and the output buffer. The output buffer holds two items; when it is full
// the input drops ready, and ready comes back the cycle after a result
// leaves. Write calibration registers only while no item is in flight.
module stick_axis_calibrate_deadband_core #(
	parameter int SAMPLE_BITS = sadb_pkg::SAMPLE_BITS_DEF,
	parameter int NORM_STEPS  = sadb_pkg::NORM_STEPS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	sadb_sample_if.sink                sample,
	sadb_result_if.source              result,
	input  logic                       cfg_we,
	input  sadb_pkg::cfg_idx_t         cfg_idx,
	input  logic [sadb_pkg::CAL_W-1:0] cfg_data
);
	import sadb_pkg::*;

	localparam int QW = quot_w(NORM_STEPS);
	localparam int XW = num_w(NORM_STEPS);
	localparam int NW = QW + 1;

	// Calibration registers
	logic [CAL_W-1:0] cal_min_q, cal_center_q, cal_max_q;
	logic             invert_q, thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_min_q    <= '0;
			cal_center_q <= CAL_W'(32767);
			cal_max_q    <= '1;
			invert_q     <= 1'b0;
			thr_q        <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_CAL_MIN:       cal_min_q    <= cfg_data;
				REG_CAL_CENTER:    cal_center_q <= cfg_data;
				REG_CAL_MAX:       cal_max_q    <= cfg_data;
				REG_INVERT_AXIS:   invert_q     <= cfg_data[0];
				REG_THROTTLE_MODE: thr_q        <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Pipeline advance, held by the output buffer
	logic en;

	assign sample.ready = en;

	ctl_t                     ctl_f, ctl_d, ctl_o;
	logic                     frc_f;
	logic [QW-1:0]            fval_f, mag_d;
	logic [XW-1:0]            x_f, d_f;
	logic signed [NW-1:0]     norm_o;
	logic signed [BYTE_W-1:0] byte_o;

	sadb_front #(
		.SW (SAMPLE_BITS),
		.N  (NORM_STEPS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_vld     (sample.valid),
		.sample     (sample.adc_sample),
		.cal_min    (cal_min_q),
		.cal_center (cal_center_q),
		.cal_max    (cal_max_q),
		.invert     (invert_q),
		.thr        (thr_q),
		.ctl_o      (ctl_f),
		.frc_o      (frc_f),
		.fval_o     (fval_f),
		.x_o        (x_f),
		.d_o        (d_f)
	);

	sadb_div #(
		.N (NORM_STEPS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.ctl_i  (ctl_f),
		.frc_i  (frc_f),
		.fval_i (fval_f),
		.x_i    (x_f),
		.d_i    (d_f),
		.ctl_o  (ctl_d),
		.mag_o  (mag_d)
	);

	sadb_scale #(
		.N (NORM_STEPS)
	) u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.ctl_i  (ctl_d),
		.mag_i  (mag_d),
		.ctl_o  (ctl_o),
		.norm_o (norm_o),
		.byte_o (byte_o)
	);

	sadb_skid #(
		.NW (NW)
	) u_skid (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (ctl_o.vld && en),
		.res_i  (ctl_o.res),
		.norm_i (norm_o),
		.byte_i (byte_o),
		.en     (en),
		.result (result)
	);

endmodule

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the stick calibration and deadband core. Samples go
// in through the valid/ready sample channel, and a built-in predictor works
// out the normalized position and command byte of each accepted item. Every
// result is compared field by field with the oldest pending prediction.
// A directed table covers the extremes and the corner cases: no reading,
// rounding, the deadband edge, zero and negative spans, inversion and
// throttle mode. Random items follow under many calibration sets, with
// random idling on both sides and one long output stall.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sadb_pkg::*;

	localparam int SW         = SAMPLE_BITS_DEF;
	localparam int NSTEPS     = NORM_STEPS_DEF;
	localparam int NW         = quot_w(NORM_STEPS_DEF) + 1;
	localparam int LAT        = quot_w(NORM_STEPS_DEF) + 6;
	localparam int FULL_SCALE = 1 << SW;
	localparam int NSEG       = 12;
	localparam int SEG_ITEMS  = 158;
	localparam int HOLD_LEN   = 300;

	typedef struct packed {
		logic                 valid_res;
		logic signed [NW-1:0] norm;
		logic signed [7:0]    sbyte;
	} stick_res_t;

	typedef struct packed {
		logic [CAL_W-1:0] lo;
		logic [CAL_W-1:0] mid;
		logic [CAL_W-1:0] hi;
		logic             inv;
		logic             thr;
	} cal_set_t;

	typedef struct packed {
		logic [2:0]    sel;
		logic [SW-1:0] smp;
		logic          known;
		stick_res_t    want;
	} dir_row_t;

	localparam stick_res_t RES_NONE = '{1'b0, 0, 0};
	localparam stick_res_t RES_MID  = '{1'b1, 0, 0};
	localparam stick_res_t RES_HI   = '{1'b1, NSTEPS, 127};
	localparam stick_res_t RES_LO   = '{1'b1, -NSTEPS, -127};

	// Calibration sets of the directed part; the first one is the reset state
	localparam cal_set_t DIR_CAL [7] = '{
		'{16'd0,    16'd32767, 16'd65535, 1'b0, 1'b0},
		'{16'd0,    16'd2048,  16'd4095,  1'b0, 1'b0},
		'{16'd0,    16'd2048,  16'd4095,  1'b1, 1'b0},
		'{16'd100,  16'd2048,  16'd4000,  1'b0, 1'b1},
		'{16'd2000, 16'd2000,  16'd2000,  1'b0, 1'b0},
		'{16'd3000, 16'd2000,  16'd1000,  1'b0, 1'b0},
		'{16'd2000, 16'd0,     16'd2000,  1'b0, 1'b1}
	};

	localparam int NDIR = 25;
	localparam dir_row_t DIR_TAB [NDIR] = '{
		// reset calibration: no reading, full low, high end of the converter
		'{3'd0, 12'd0,    1'b1, RES_NONE},
		'{3'd0, 12'd1,    1'b1, RES_LO},
		'{3'd0, 12'd4095, 1'b0, '0},
		// centered calibration: center, ends, deadband edge, half-step rounding
		'{3'd1, 12'd2048, 1'b1, RES_MID},
		'{3'd1, 12'd4095, 1'b1, RES_HI},
		'{3'd1, 12'd1,    1'b1, RES_LO},
		'{3'd1, 12'd2096, 1'b0, '0},
		'{3'd1, 12'd2100, 1'b0, '0},
		'{3'd1, 12'd2116, 1'b0, '0},
		'{3'd1, 12'd1980, 1'b0, '0},
		'{3'd1, 12'd2046, 1'b0, '0},
		'{3'd1, 12'd0,    1'b1, RES_NONE},
		// inverted axis
		'{3'd2, 12'd1,    1'b1, RES_HI},
		'{3'd2, 12'd4095, 1'b1, RES_LO},
		'{3'd2, 12'd2048, 1'b1, RES_MID},
		// throttle: below min, above max, at min, middle
		'{3'd3, 12'd50,   1'b1, RES_MID},
		'{3'd3, 12'd4095, 1'b1, RES_HI},
		'{3'd3, 12'd100,  1'b1, RES_MID},
		'{3'd3, 12'd2050, 1'b0, '0},
		// zero span on both sides
		'{3'd4, 12'd3000, 1'b1, RES_HI},
		'{3'd4, 12'd1000, 1'b1, RES_LO},
		'{3'd4, 12'd2000, 1'b1, RES_MID},
		// reversed calibration points flip the sign
		'{3'd5, 12'd1500, 1'b0, '0},
		'{3'd5, 12'd2500, 1'b0, '0},
		// throttle with zero span
		'{3'd6, 12'd3000, 1'b1, RES_HI}
	};

	logic                clk    = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we;
	cfg_idx_t            cfg_idx;
	logic [CAL_W-1:0]    cfg_data;

	sadb_sample_if #(.SW(SW)) smp ();
	sadb_result_if #(.NW(NW)) res ();

	stick_res_t pending_pos [$];
	cal_set_t   cal_now      = DIR_CAL[0];
	int         snd_idle     = 27;
	int         rcv_idle_pct = 81;
	int         hold_kick    = 0;
	int         mismatches   = 0;

	stick_axis_calibrate_deadband_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.sample   (smp),
		.result   (res),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Round half away from zero of num * NSTEPS / den, magnitude clamped
	function automatic longint span_quot(longint num, longint den);
		longint a;
		longint d;
		longint mag;
		a = (num < 0) ? -num : num;
		d = (den < 0) ? -den : den;
		if (d == 0) begin
			if (num == 0)
				return 0;
			return (num > 0) ? NSTEPS : -NSTEPS;
		end
		mag = (2 * a * NSTEPS + d) / (2 * d);
		if (mag > NSTEPS)
			mag = NSTEPS;
		return ((num < 0) != (den < 0)) ? -mag : mag;
	endfunction

	// Position and command byte of one sample under the current calibration
	function automatic stick_res_t calc_stick(logic [SW-1:0] sample, cal_set_t c);
		longint raw;
		longint lo;
		longint mid;
		longint hi;
		longint n;
		longint s;
		longint a;
		stick_res_t r;
		raw = longint'(sample);
		lo  = longint'(c.lo);
		mid = longint'(c.mid);
		hi  = longint'(c.hi);
		if (raw == 0)
			return RES_NONE;
		if (c.inv)
			raw = FULL_SCALE - raw;
		if (c.thr) begin
			n = span_quot(raw - lo, hi - lo);
			if (n < 0)
				n = 0;
			s = n * 127 / NSTEPS;
		end else begin
			n = span_quot(raw - mid, (raw < mid) ? mid - lo : hi - mid);
			a = (n < 0) ? -n : n;
			if (40 * a <= NSTEPS) begin
				s = 0;
			end else begin
				s = (40 * a - NSTEPS) * 127 / (39 * NSTEPS);
				if (s > 127)
					s = 127;
				if (n < 0)
					s = -s;
			end
		end
		r.valid_res = 1'b1;
		r.norm      = n[NW-1:0];
		r.sbyte     = s[7:0];
		return r;
	endfunction

	// Offer one sample, idling first at random, and log its expected result
	task automatic push_sample(input logic [SW-1:0] s, input logic known,
		input stick_res_t want);
		while ($urandom_range(0, 99) < snd_idle) begin
			smp.valid <= 1'b0;
			@(posedge clk);
		end
		smp.valid      <= 1'b1;
		smp.adc_sample <= s;
		do
			@(posedge clk);
		while (!smp.ready);
		pending_pos.push_back(known ? want : calc_stick(s, cal_now));
	endtask

	// Drain the pipeline, then load a full calibration set
	task automatic recalibrate(input cal_set_t c);
		smp.valid <= 1'b0;
		while (pending_pos.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= REG_CAL_MIN;
		cfg_data <= c.lo;
		@(posedge clk);
		cfg_idx  <= REG_CAL_CENTER;
		cfg_data <= c.mid;
		@(posedge clk);
		cfg_idx  <= REG_CAL_MAX;
		cfg_data <= c.hi;
		@(posedge clk);
		cfg_idx  <= REG_INVERT_AXIS;
		cfg_data <= CAL_W'(c.inv);
		@(posedge clk);
		cfg_idx  <= REG_THROTTLE_MODE;
		cfg_data <= CAL_W'(c.thr);
		@(posedge clk);
		cfg_we  <= 1'b0;
		cal_now = c;
	endtask

	task automatic match_field(input string fname, input logic signed [31:0] want_v,
		input logic signed [31:0] got_v);
		if (got_v !== want_v) begin
			$display("%0t ns: %s expected %0d, got %0d", $time, fname, want_v, got_v);
			mismatches++;
		end
	endtask

	// Result side: check each item, stall at random or for a long hold
	initial begin
		int hold_seen;
		int hold_left;
		stick_res_t want;
		hold_seen = 0;
		hold_left = 0;
		res.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && res.valid && res.ready) begin
				if (pending_pos.size() == 0) begin
					$display("%0t ns: result with no item pending, expected none, got %0d %0d %0d",
						$time, res.valid_res, res.norm_steps, res.stick_byte);
					mismatches++;
				end else begin
					want = pending_pos.pop_front();
					match_field("valid_res", want.valid_res, res.valid_res);
					match_field("norm_steps", want.norm, res.norm_steps);
					match_field("stick_byte", want.sbyte, res.stick_byte);
				end
			end
			if (hold_kick != hold_seen) begin
				hold_seen = hold_kick;
				hold_left = HOLD_LEN;
			end
			if (hold_left != 0) begin
				hold_left--;
				res.ready <= 1'b0;
			end else begin
				res.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
			end
		end
	end

	// Stimulus
	initial begin
		cal_set_t      c;
		logic [SW-1:0] s_val;
		int            cal_sel;
		int            pick;
		int            ctr;
		cal_sel = 0;
		smp.valid      <= 1'b0;
		smp.adc_sample <= '0;
		cfg_we         <= 1'b0;
		cfg_idx        <= REG_CAL_MIN;
		cfg_data       <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table
		for (int i = 0; i < NDIR; i++) begin
			if (DIR_TAB[i].sel != cal_sel) begin
				cal_sel = DIR_TAB[i].sel;
				recalibrate(DIR_CAL[cal_sel]);
			end
			push_sample(DIR_TAB[i].smp, DIR_TAB[i].known, DIR_TAB[i].want);
		end

		// Random segments, each under a fresh calibration set
		for (int seg = 0; seg < NSEG; seg++) begin
			if (seg == 0) begin
				c = '0;
			end else if (seg == NSEG - 1) begin
				c = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1};
			end else begin
				case ($urandom_range(0, 4))
					0: begin
						// typical stick
						c.lo  = CAL_W'($urandom_range(0, 400));
						c.mid = CAL_W'($urandom_range(1500, 2600));
						c.hi  = CAL_W'($urandom_range(3600, 4095));
					end
					1: begin
						c.lo  = CAL_W'($urandom_range(0, 65535));
						c.mid = CAL_W'($urandom_range(0, 65535));
						c.hi  = CAL_W'($urandom_range(0, 65535));
					end
					2: begin
						// collapsed spans
						c.mid = CAL_W'($urandom_range(0, 4095));
						c.lo  = c.mid;
						c.hi  = ($urandom_range(0, 1) != 0) ? c.mid
							: CAL_W'($urandom_range(0, 4095));
					end
					3: begin
						// badly ordered points
						c.lo  = CAL_W'($urandom_range(2500, 4095));
						c.mid = CAL_W'($urandom_range(1600, 2400));
						c.hi  = CAL_W'($urandom_range(0, 1500));
					end
					default: begin
						// narrow spans saturate quickly
						c.mid = CAL_W'($urandom_range(64, 4031));
						c.lo  = c.mid - CAL_W'($urandom_range(0, 63));
						c.hi  = c.mid + CAL_W'($urandom_range(0, 63));
					end
				endcase
				c.inv = 1'($urandom_range(0, 1));
				c.thr = 1'($urandom_range(0, 1));
			end
			recalibrate(c);

			case (seg / 4)
				0: begin
					snd_idle = 27;
					rcv_idle_pct <= 81;
				end
				1: begin
					snd_idle = 81;
					rcv_idle_pct <= 27;
				end
				default: begin
					snd_idle = 0;
					rcv_idle_pct <= 0;
				end
			endcase
			// long output stall while samples keep coming
			if (seg == 8)
				hold_kick <= hold_kick + 1;

			for (int k = 0; k < SEG_ITEMS; k++) begin
				pick = $urandom_range(0, 99);
				if (pick < 4) begin
					s_val = '0;
				end else if (pick < 8) begin
					s_val = pick[0] ? '1 : SW'(1);
				end else if (pick < 40) begin
					// cluster around the reference point, through the deadband
					ctr = c.thr ? int'(c.lo) : int'(c.mid);
					if (ctr > FULL_SCALE - 1)
						ctr = int'($urandom_range(1, FULL_SCALE - 1));
					ctr = ctr + int'($urandom_range(0, 400)) - 200;
					if (ctr < 1)
						ctr = 1;
					if (ctr > FULL_SCALE - 1)
						ctr = FULL_SCALE - 1;
					if (c.inv)
						ctr = FULL_SCALE - ctr;
					s_val = ctr[SW-1:0];
				end else begin
					s_val = SW'($urandom_range(1, FULL_SCALE - 1));
				end
				push_sample(s_val, 1'b0, '0);
			end
		end

		// Drain and let the pipeline settle
		smp.valid <= 1'b0;
		while (pending_pos.size() != 0)
			@(posedge clk);
		repeat (LAT + 8) @(posedge clk);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Watchdog
	initial begin
		#10_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
